/* hw/rtl/newton_cooling_ode_stepper_core_assert.svh */
// assertion macros for the cooling stepper core
`ifndef NEWTON_COOLING_ODE_STEPPER_CORE_ASSERT_SVH
`define NEWTON_COOLING_ODE_STEPPER_CORE_ASSERT_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define NCS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ncs assertion failed");
// condition must never be seen at a clock edge outside reset
`define NCS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("ncs forbidden condition seen");
`else
`define NCS_ASSERT(lbl, clk, rst_n, prop)
`define NCS_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

/* hw/rtl/ncs_pkg.sv */
// shared widths, codes, reset values and helpers of the cooling stepper
package ncs_pkg;

  // fixed-point formats
  localparam int FracBits = 16;
  localparam int TempW    = 32;
  localparam int TimeW    = 48;
  localparam int CoefW    = 32;
  localparam int StepW    = 32;
  localparam int MethW    = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 48;

  // datapath widths
  localparam int DiffW    = TempW + 1;
  localparam int RateW    = DiffW;
  localparam int ProdW    = CoefW + DiffW + 1;
  localparam int IncW     = StepW + RateW - FracBits;
  localparam int SumW     = IncW + 3;
  localparam int MagW     = TempW + 4;
  localparam int DivSteps = MagW / 2;
  localparam int DivCntW  = $clog2(DivSteps);

  // largest dividend magnitude that still matters after saturation: 6 * 2^(TempW+1)
  localparam logic [MagW-1:0] ClampMag = {3'b110, {(TempW + 1){1'b0}}};

  // integrator codes, the unused code acts as fourth order
  localparam logic [MethW-1:0] MethodHeun = 2'd0;
  localparam logic [MethW-1:0] MethodMid  = 2'd1;
  localparam logic [MethW-1:0] MethodRk4  = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgMethod  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCoeff   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgStep    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgAmbient = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgStart   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgEnd     = 3'd5;

  // register reset values
  localparam logic [MethW-1:0] RstMethod  = MethodHeun;
  localparam logic [CoefW-1:0] RstCoeff   = 32'd4294967;
  localparam logic [StepW-1:0] RstStep    = 32'd655360;
  localparam logic [TempW-1:0] RstAmbient = 32'd1310720;
  localparam logic [TempW-1:0] RstStart   = 32'd6553600;
  localparam logic [TimeW-1:0] RstEnd     = 48'd155582464;

  // sequencer states
  typedef enum logic [6:0] {
    StIdle    = 7'b0000001,
    StMulRate = 7'b0000010,
    StMulInc  = 7'b0000100,
    StAcc     = 7'b0001000,
    StDivInit = 7'b0010000,
    StDiv     = 7'b0100000,
    StFin     = 7'b1000000
  } state_e;

  // clamp a wide signed value to the temperature range
  function automatic logic signed [TempW-1:0] sat_temp(input logic signed [SumW:0] v);
    logic signed [SumW:0] hi;
    logic signed [SumW:0] lo;
    hi = {{(SumW + 2 - TempW){1'b0}}, {(TempW - 1){1'b1}}};
    lo = {{(SumW + 2 - TempW){1'b1}}, {(TempW - 1){1'b0}}};
    if (v > hi) begin
      sat_temp = hi[TempW-1:0];
    end else if (v < lo) begin
      sat_temp = lo[TempW-1:0];
    end else begin
      sat_temp = v[TempW-1:0];
    end
  endfunction

endpackage

/* hw/rtl/ncs_if.sv */
// valid/ready channels for tick words and sample words

interface ncs_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface ncs_out_if;
  logic                              valid;
  logic                              ready;
  logic [ncs_pkg::TimeW-1:0]         elapsed_time;
  logic signed [ncs_pkg::TempW-1:0]  temperature;
  logic                              last_sample;

  modport source (output valid, output elapsed_time, output temperature,
                  output last_sample, input ready);
  modport sink (input valid, input elapsed_time, input temperature,
                input last_sample, output ready);
endinterface

/* hw/rtl/newton_cooling_ode_stepper_core.sv */
// Cooling stepper: emits a sample per tick word inside the run, then advances the temperature one step.
// Sample word is registered in the cycle after the tick word is accepted.
// The step runs on one shared 33x33 multiplier and a 2-bit-per-cycle divide by six:
// Heun and midpoint run two multiply/accumulate passes, fourth order runs four passes and then the divide;
// a new tick word is taken only back in idle, and skipped ticks leave the sequencer idle.
// Reset (rst_ni low, asynchronous) loads register defaults, time zero, start temperature.
`include "newton_cooling_ode_stepper_core_assert.svh"

module newton_cooling_ode_stepper_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ncs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ncs_pkg::CfgDataW-1:0]  cfg_wdata_i,
  ncs_in_if.sink                        in_i,
  ncs_out_if.source                     out_o
);

  localparam int TempW = ncs_pkg::TempW;
  localparam int TimeW = ncs_pkg::TimeW;
  localparam int SumW  = ncs_pkg::SumW;
  localparam int IncW  = ncs_pkg::IncW;
  localparam int MagW  = ncs_pkg::MagW;

  // configuration registers
  logic [ncs_pkg::MethW-1:0]  method_q;
  logic [ncs_pkg::CoefW-1:0]  coeff_q;
  logic [ncs_pkg::StepW-1:0]  step_q;
  logic signed [TempW-1:0]    amb_q;
  logic signed [TempW-1:0]    start_q;
  logic [TimeW-1:0]           end_q;

  // run state and sequencer
  ncs_pkg::state_e                state_q, state_d;
  logic signed [TempW-1:0]        cur_temp_q;
  logic [TimeW-1:0]               cur_time_q;
  logic                           run_over_q;
  logic [1:0]                     idx_q;
  logic signed [TempW-1:0]        x_q;
  logic signed [ncs_pkg::ProdW-1:0] prod_q;
  logic signed [SumW-1:0]         sum_q;
  logic [MagW-1:0]                mag_q;
  logic [MagW-1:0]                quo_q;
  logic [2:0]                     rem_q;
  logic                           neg_q;
  logic [ncs_pkg::DivCntW-1:0]    cnt_q;

  // output word register
  logic                           out_valid_q;
  logic [TimeW-1:0]               out_time_q;
  logic signed [TempW-1:0]        out_temp_q;
  logic                           out_last_q;

  // handshake
  logic in_acc;
  logic out_free;
  assign out_free    = !out_valid_q || out_o.ready;
  assign in_i.ready  = (state_q == ncs_pkg::StIdle) && out_free;
  assign in_acc      = in_i.valid && in_i.ready;

  assign out_o.valid        = out_valid_q;
  assign out_o.elapsed_time = out_time_q;
  assign out_o.temperature  = out_temp_q;
  assign out_o.last_sample  = out_last_q;

  // tick decision
  logic [TimeW-1:0]        time_eff;
  logic signed [TempW-1:0] temp_eff;
  logic                    over_eff;
  logic                    emit;
  logic [TimeW:0]          next_time;
  logic                    last;
  assign time_eff  = in_i.restart ? '0 : cur_time_q;
  assign temp_eff  = in_i.restart ? start_q : cur_temp_q;
  assign over_eff  = !in_i.restart && run_over_q;
  assign emit      = !over_eff && (time_eff <= end_q);
  assign next_time = {1'b0, time_eff} + (TimeW + 1)'(step_q);
  assign last      = next_time > {1'b0, end_q};

  // method decode
  logic is_heun;
  logic is_mid;
  logic is_rk4;
  always_comb begin
    is_heun = 1'b0;
    is_mid  = 1'b0;
    is_rk4  = 1'b0;
    case (method_q)
      ncs_pkg::MethodHeun: is_heun = 1'b1;
      ncs_pkg::MethodMid:  is_mid  = 1'b1;
      default:             is_rk4  = 1'b1;
    endcase
  end

  // shared multiplier: k * (ambient - x), then h * rate
  logic signed [ncs_pkg::DiffW-1:0] diff;
  logic signed [ncs_pkg::RateW-1:0] rate;
  logic [ncs_pkg::CoefW-1:0]        mul_a;
  logic signed [ncs_pkg::RateW-1:0] mul_b;
  logic signed [ncs_pkg::ProdW-1:0] prod_d;
  assign diff   = {amb_q[TempW-1], amb_q} - {x_q[TempW-1], x_q};
  assign rate   = prod_q[ncs_pkg::CoefW +: ncs_pkg::RateW];
  assign mul_a  = (state_q == ncs_pkg::StMulRate) ? coeff_q : step_q;
  assign mul_b  = (state_q == ncs_pkg::StMulRate) ? diff : rate;
  assign prod_d = $signed({1'b0, mul_a}) * mul_b;

  // increment accumulation and next stage operand
  logic signed [IncW-1:0]   inc;
  logic signed [IncW-1:0]   inc_half;
  logic signed [SumW-1:0]   base;
  logic signed [SumW-1:0]   inc_term;
  logic signed [SumW-1:0]   sum_next;
  logic                     weight2;
  logic                     use_half;
  logic                     done_inc;
  logic signed [SumW:0]     t0_ext;
  logic signed [SumW:0]     x_sum;
  logic signed [TempW-1:0]  x_next;
  assign inc      = prod_q[ncs_pkg::FracBits +: IncW];
  assign inc_half = inc >>> 1;
  assign weight2  = is_rk4 && ((idx_q == 2'd1) || (idx_q == 2'd2));
  assign use_half = !is_heun && !(is_rk4 && (idx_q == 2'd2));
  assign done_inc = is_rk4 ? (idx_q == 2'd3) : (idx_q == 2'd1);
  assign base     = ((idx_q == 2'd0) || is_mid) ? '0 : sum_q;
  assign inc_term = weight2 ? {{(SumW - IncW - 1){inc[IncW-1]}}, inc, 1'b0}
                            : {{(SumW - IncW){inc[IncW-1]}}, inc};
  assign sum_next = base + inc_term;
  assign t0_ext   = {{(SumW + 1 - TempW){cur_temp_q[TempW-1]}}, cur_temp_q};
  assign x_sum    = t0_ext + (use_half ? {{(SumW + 1 - IncW){inc_half[IncW-1]}}, inc_half}
                                       : {{(SumW + 1 - IncW){inc[IncW-1]}}, inc});
  assign x_next   = ncs_pkg::sat_temp(x_sum);

  // divide-by-six setup: clamp and take magnitude
  logic [SumW-1:0] mag_full;
  logic [MagW-1:0] mag_init;
  assign mag_full = sum_q[SumW-1] ? SumW'(-sum_q) : sum_q;
  assign mag_init = (mag_full > SumW'(ncs_pkg::ClampMag)) ? ncs_pkg::ClampMag
                                                           : mag_full[MagW-1:0];

  // one radix-4 digit per cycle
  logic [4:0] dv;
  logic [1:0] dd;
  logic [4:0] dsub;
  logic [4:0] dres;
  assign dv = {rem_q, mag_q[MagW-1 -: 2]};
  always_comb begin
    if (dv >= 5'd18) begin
      dd   = 2'd3;
      dsub = 5'd18;
    end else if (dv >= 5'd12) begin
      dd   = 2'd2;
      dsub = 5'd12;
    end else if (dv >= 5'd6) begin
      dd   = 2'd1;
      dsub = 5'd6;
    end else begin
      dd   = 2'd0;
      dsub = 5'd0;
    end
  end
  assign dres = dv - dsub;

  // final update of the temperature
  logic signed [SumW-1:0] sum_half;
  logic signed [SumW:0]   quo_ext;
  logic signed [SumW:0]   addend;
  logic signed [TempW-1:0] temp_new;
  assign sum_half = sum_q >>> 1;
  assign quo_ext  = {{(SumW + 1 - MagW){1'b0}}, quo_q};
  always_comb begin
    if (is_heun) begin
      addend = {sum_half[SumW-1], sum_half};
    end else if (is_mid) begin
      addend = {sum_q[SumW-1], sum_q};
    end else if (neg_q) begin
      addend = ~quo_ext + (SumW + 1)'(rem_q == 3'd0);
    end else begin
      addend = quo_ext;
    end
  end
  assign temp_new = ncs_pkg::sat_temp(t0_ext + addend);

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ncs_pkg::StIdle: begin
        if (in_acc && emit) state_d = ncs_pkg::StMulRate;
      end
      ncs_pkg::StMulRate: state_d = ncs_pkg::StMulInc;
      ncs_pkg::StMulInc:  state_d = ncs_pkg::StAcc;
      ncs_pkg::StAcc: begin
        if (!done_inc) begin
          state_d = ncs_pkg::StMulRate;
        end else if (is_rk4) begin
          state_d = ncs_pkg::StDivInit;
        end else begin
          state_d = ncs_pkg::StFin;
        end
      end
      ncs_pkg::StDivInit: state_d = ncs_pkg::StDiv;
      ncs_pkg::StDiv: begin
        if (cnt_q == ncs_pkg::DivCntW'(ncs_pkg::DivSteps - 1)) state_d = ncs_pkg::StFin;
      end
      ncs_pkg::StFin: state_d = ncs_pkg::StIdle;
      default:        state_d = ncs_pkg::StIdle;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q <= ncs_pkg::RstMethod;
      coeff_q  <= ncs_pkg::RstCoeff;
      step_q   <= ncs_pkg::RstStep;
      amb_q    <= ncs_pkg::RstAmbient;
      start_q  <= ncs_pkg::RstStart;
      end_q    <= ncs_pkg::RstEnd;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ncs_pkg::CfgMethod:  method_q <= cfg_wdata_i[ncs_pkg::MethW-1:0];
        ncs_pkg::CfgCoeff:   coeff_q  <= cfg_wdata_i[ncs_pkg::CoefW-1:0];
        ncs_pkg::CfgStep:    step_q   <= cfg_wdata_i[ncs_pkg::StepW-1:0];
        ncs_pkg::CfgAmbient: amb_q    <= cfg_wdata_i[TempW-1:0];
        ncs_pkg::CfgStart:   start_q  <= cfg_wdata_i[TempW-1:0];
        ncs_pkg::CfgEnd:     end_q    <= cfg_wdata_i[TimeW-1:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ncs_pkg::StIdle;
      cur_temp_q  <= ncs_pkg::RstStart;
      cur_time_q  <= '0;
      run_over_q  <= 1'b0;
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // output word: loaded on an emitting tick, cleared when taken
      if (in_acc && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ncs_pkg::StIdle: begin
          if (in_acc && emit) begin
            cur_temp_q  <= temp_eff;
            run_over_q  <= last;
            cur_time_q  <= last ? time_eff : next_time[TimeW-1:0];
            idx_q       <= '0;
          end
        end
        ncs_pkg::StAcc: begin
          idx_q <= idx_q + 2'd1;
        end
        ncs_pkg::StDivInit: begin
          cnt_q <= '0;
        end
        ncs_pkg::StDiv: begin
          cnt_q <= cnt_q + 1'b1;
        end
        ncs_pkg::StFin: begin
          cur_temp_q <= temp_new;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ncs_pkg::StIdle: begin
        if (in_acc && emit) begin
          x_q        <= temp_eff;
          out_time_q <= time_eff;
          out_temp_q <= temp_eff;
          out_last_q <= last;
        end
      end
      ncs_pkg::StMulRate, ncs_pkg::StMulInc: begin
        prod_q <= prod_d;
      end
      ncs_pkg::StAcc: begin
        sum_q <= sum_next;
        x_q   <= x_next;
      end
      ncs_pkg::StDivInit: begin
        mag_q <= mag_init;
        neg_q <= sum_q[SumW-1];
        rem_q <= '0;
        quo_q <= '0;
      end
      ncs_pkg::StDiv: begin
        mag_q <= {mag_q[MagW-3:0], 2'b00};
        quo_q <= {quo_q[MagW-3:0], dd};
        rem_q <= dres[2:0];
      end
      default: ;
    endcase
  end

  // checks
  `NCS_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, in_acc && out_valid_q && !out_o.ready)
  `NCS_ASSERT(a_run_over_silent, clk_i, rst_ni, in_acc && run_over_q && !in_i.restart |=> !out_valid_q)
  `NCS_ASSERT(a_restart_time_zero, clk_i, rst_ni, in_acc && in_i.restart |=> out_valid_q && (out_time_q == '0))
  `NCS_ASSERT(a_busy_not_ready, clk_i, rst_ni, (state_q != ncs_pkg::StIdle) |-> !in_i.ready)

endmodule

/* sim/tb.sv */
// testbench for the cooling stepper core: directed and random tick streams, self-checking
`timescale 1ns / 1ps

module tb;

  localparam int TempW    = ncs_pkg::TempW;
  localparam int TimeW    = ncs_pkg::TimeW;
  localparam int CoefW    = ncs_pkg::CoefW;
  localparam int StepW    = ncs_pkg::StepW;
  localparam int MethW    = ncs_pkg::MethW;
  localparam int CfgIdxW  = ncs_pkg::CfgIdxW;
  localparam int CfgDataW = ncs_pkg::CfgDataW;
  localparam int FracBits = ncs_pkg::FracBits;

  // one expected sample word
  typedef struct packed {
    logic [TimeW-1:0]        elapsed;
    logic signed [TempW-1:0] temp;
    logic                    last;
  } sample_t;

  localparam longint TempMax = (64'sd1 <<< (TempW - 1)) - 1;
  localparam longint TempMin = -(64'sd1 <<< (TempW - 1));
  // idle clocks after the queues drain; covers the longest (fourth-order) step with margin
  localparam int StepSettle = 40;
  localparam int RandTicks  = 500;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  ncs_in_if  tick_if ();
  ncs_out_if samp_if ();

  newton_cooling_ode_stepper_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (tick_if),
    .out_o       (samp_if)
  );

  always #4 clk_i = ~clk_i;

  // register copies and integrator state of the predictor
  logic [MethW-1:0]        m_method;
  logic [CoefW-1:0]        m_coeff;
  logic [StepW-1:0]        m_step;
  logic signed [TempW-1:0] m_ambient;
  logic signed [TempW-1:0] m_start;
  logic [TimeW-1:0]        m_end;
  longint                  t_temp;
  logic [TimeW-1:0]        t_time;
  bit                      t_over;

  bit      pending_ticks[$];
  sample_t expected_samples[$];
  int      src_idle_pct;
  int      sink_idle_pct;
  int      error_count;
  int      ticks_accepted;
  int      samples_checked;
  int      cfg_writes;
  int      rand_ticks;

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= 30) $display("[%0t] ERROR: %s", $time, msg);
  endtask

  // floor(a * b / 2^sh) at full width
  function automatic longint floor_mul(input logic [31:0] a, input longint b, input int sh);
    logic signed [97:0] aw;
    logic signed [97:0] bw;
    logic signed [97:0] p;
    aw = $signed({66'd0, a});
    bw = b;
    p = (aw * bw) >>> sh;
    return longint'(p[63:0]);
  endfunction

  function automatic longint floor_div(input longint s, input longint d);
    longint q;
    q = s / d;
    if ((s % d) != 0 && s < 0) q -= 1;
    return q;
  endfunction

  function automatic longint clamp_temp(input longint v);
    if (v > TempMax) return TempMax;
    if (v < TempMin) return TempMin;
    return v;
  endfunction

  // temperature change over one step from temperature t
  function automatic longint step_delta(input longint t);
    longint diff;
    longint rate;
    diff = longint'(m_ambient) - t;
    rate = floor_mul(m_coeff, diff, 32);
    return floor_mul(m_step, rate, FracBits);
  endfunction

  function automatic longint next_temp(input longint t0);
    longint a, b, c, d;
    a = step_delta(t0);
    case (m_method)
      ncs_pkg::MethodHeun: begin
        b = step_delta(clamp_temp(t0 + a));
        return clamp_temp(t0 + floor_div(a + b, 2));
      end
      ncs_pkg::MethodMid: begin
        b = step_delta(clamp_temp(t0 + floor_div(a, 2)));
        return clamp_temp(t0 + b);
      end
      default: begin
        b = step_delta(clamp_temp(t0 + floor_div(a, 2)));
        c = step_delta(clamp_temp(t0 + floor_div(b, 2)));
        d = step_delta(clamp_temp(t0 + c));
        return clamp_temp(t0 + floor_div(a + 2 * b + 2 * c + d, 6));
      end
    endcase
  endfunction

  // one tick: returns 1 with the sample word it emits
  function automatic bit cooling_predict(input bit restart, output sample_t s);
    logic [63:0] nxt;
    bit last;
    s = '0;
    if (restart) begin
      t_time = '0;
      t_temp = longint'(m_start);
      t_over = 1'b0;
    end
    if (t_over || t_time > m_end) return 1'b0;
    nxt  = {16'd0, t_time} + {32'd0, m_step};
    last = nxt > {16'd0, m_end};
    s.elapsed = t_time;
    s.temp    = t_temp[TempW-1:0];
    s.last    = last;
    t_temp = next_temp(t_temp);
    if (last) t_over = 1'b1;
    else t_time = nxt[TimeW-1:0];
    return 1'b1;
  endfunction

  // tick driver
  always @(posedge clk_i or negedge rst_ni) begin
    bit      nxt_valid;
    bit      nxt_restart;
    sample_t s;
    if (!rst_ni) begin
      tick_if.valid   <= 1'b0;
      tick_if.restart <= 1'b0;
    end else begin
      nxt_valid   = tick_if.valid;
      nxt_restart = tick_if.restart;
      if (tick_if.valid && tick_if.ready) begin
        ticks_accepted++;
        if (cooling_predict(tick_if.restart, s))
          expected_samples.insert(expected_samples.size(), s);
        void'(pending_ticks.pop_front());
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending_ticks.size() != 0 &&
          $urandom_range(99) >= src_idle_pct) begin
        nxt_valid   = 1'b1;
        nxt_restart = pending_ticks[0];
      end
      tick_if.valid   <= nxt_valid;
      tick_if.restart <= nxt_restart;
    end
  end

  // sample monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    sample_t want;
    if (!rst_ni) begin
      samp_if.ready <= 1'b0;
    end else begin
      if (samp_if.valid && samp_if.ready) begin
        if (expected_samples.size() == 0) begin
          report_error($sformatf("sample word at time %0h with none expected",
                                 samp_if.elapsed_time));
        end else begin
          want = expected_samples.pop_front();
          samples_checked++;
          if (samp_if.elapsed_time !== want.elapsed)
            report_error($sformatf("elapsed_time %0h, expected %0h",
                                   samp_if.elapsed_time, want.elapsed));
          if (samp_if.temperature !== want.temp)
            report_error($sformatf("temperature %0d at time %0h, expected %0d",
                                   samp_if.temperature, want.elapsed, want.temp));
          if (samp_if.last_sample !== want.last)
            report_error($sformatf("last_sample %0b at time %0h, expected %0b",
                                   samp_if.last_sample, want.elapsed, want.last));
        end
      end
      samp_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // write the registers picked by mask, one per cycle, and mirror them
  task automatic load_regs(input logic [5:0] mask, input logic [MethW-1:0] meth,
                           input logic [CoefW-1:0] coeff, input logic [StepW-1:0] step,
                           input logic [TempW-1:0] amb, input logic [TempW-1:0] strt,
                           input logic [TimeW-1:0] tend);
    logic [CfgDataW-1:0] vals [6];
    vals[ncs_pkg::CfgMethod]  = CfgDataW'(meth);
    vals[ncs_pkg::CfgCoeff]   = CfgDataW'(coeff);
    vals[ncs_pkg::CfgStep]    = CfgDataW'(step);
    vals[ncs_pkg::CfgAmbient] = CfgDataW'(amb);
    vals[ncs_pkg::CfgStart]   = CfgDataW'(strt);
    vals[ncs_pkg::CfgEnd]     = CfgDataW'(tend);
    for (int i = 0; i <= int'(ncs_pkg::CfgEnd); i++) begin
      if (mask[i]) begin
        @(posedge clk_i);
        cfg_we_i    <= 1'b1;
        cfg_idx_i   <= CfgIdxW'(i);
        cfg_wdata_i <= vals[i];
        cfg_writes++;
        case (CfgIdxW'(i))
          ncs_pkg::CfgMethod:  m_method  = meth;
          ncs_pkg::CfgCoeff:   m_coeff   = coeff;
          ncs_pkg::CfgStep:    m_step    = step;
          ncs_pkg::CfgAmbient: m_ambient = amb;
          ncs_pkg::CfgStart:   m_start   = strt;
          ncs_pkg::CfgEnd:     m_end     = tend;
          default: ;
        endcase
      end
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // queue n ticks, bit i of pattern is the restart flag of tick i
  task automatic queue_ticks(input logic [15:0] pattern, input int n);
    for (int i = 0; i < n; i++) pending_ticks.insert(pending_ticks.size(), pattern[i]);
  endtask

  // wait until every tick is taken and every sample seen, then let the step finish
  task automatic settle();
    while (pending_ticks.size() != 0 || expected_samples.size() != 0) @(posedge clk_i);
    repeat (StepSettle) @(posedge clk_i);
  endtask

  function automatic logic [CoefW-1:0] pick_coeff();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom();
      default: return $urandom_range(0, 32'h1000_0000);
    endcase
  endfunction

  function automatic logic [StepW-1:0] pick_step();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return $urandom();
      default: return $urandom_range(32'h0000_1000, 32'h0010_0000);
    endcase
  endfunction

  function automatic logic [TempW-1:0] pick_temp();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return $urandom();
      default: return ($urandom_range(0, 400) << FracBits) - (32'd100 << FracBits);
    endcase
  endfunction

  // mostly end times a few steps away so runs finish quickly
  function automatic logic [TimeW-1:0] pick_end(input logic [StepW-1:0] step);
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return r[TimeW-1:0];
      default: return TimeW'(step) * TimeW'($urandom_range(0, 10)) +
                      TimeW'($urandom_range(0, step));
    endcase
  endfunction

  // run limit
  initial begin
    #8_000_000;
    $display("timeout with %0d ticks queued and %0d samples outstanding",
             pending_ticks.size(), expected_samples.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [StepW-1:0] step;
    int runs;
    int len;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_wdata_i     = '0;
    rst_ni          = 1'b0;
    src_idle_pct    = 35;
    sink_idle_pct   = 84;
    m_method  = ncs_pkg::RstMethod;
    m_coeff   = ncs_pkg::RstCoeff;
    m_step    = ncs_pkg::RstStep;
    m_ambient = ncs_pkg::RstAmbient;
    m_start   = ncs_pkg::RstStart;
    m_end     = ncs_pkg::RstEnd;
    t_temp    = longint'($signed(ncs_pkg::RstStart));
    t_time    = '0;
    t_over    = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset state and defaults: ticks before and after a restart
    queue_ticks(16'b0100, 4);
    settle();
    // midpoint with extreme coefficient, step and temperatures, saturating
    load_regs(6'b111111, ncs_pkg::MethodMid, '1, '1, 32'h7FFF_FFFF, 32'h8000_0000, '1);
    queue_ticks(16'b001, 3);
    settle();
    // fourth order with zero step: time stays put, never last
    load_regs(6'b101101, ncs_pkg::MethodRk4, '1, '0, 32'h8000_0000, 32'h7FFF_FFFF, '1);
    queue_ticks(16'b001, 3);
    settle();
    // unused method code, run ends after three samples then stays over
    load_regs(6'b111111, 2'd3, 32'h0800_0000, 32'h0001_0000, 32'h0014_0000,
              32'h0064_0000, 48'h0002_8000);
    queue_ticks(16'b00001, 5);
    settle();
    // raising the end time does not resume a finished run
    load_regs(6'b100000, '0, '0, '0, '0, '0, '1);
    queue_ticks(16'b10, 2);
    settle();
    // end time lowered mid-run: ticks skipped until it rises again
    load_regs(6'b100001, ncs_pkg::MethodRk4, '0, '0, '0, '0, 48'h0100_0000);
    queue_ticks(16'b001, 3);
    settle();
    load_regs(6'b100000, '0, '0, '0, '0, '0, 48'h0001_0000);
    queue_ticks(16'b0, 1);
    settle();
    load_regs(6'b100000, '0, '0, '0, '0, '0, 48'h0100_0000);
    queue_ticks(16'b0, 1);
    settle();

    // random blocks: new settings, then restart-led runs with some noise
    rand_ticks = 0;
    while (rand_ticks < RandTicks) begin
      if (rand_ticks < RandTicks / 3) begin
        src_idle_pct  = 35;
        sink_idle_pct = 84;
      end else if (rand_ticks < 2 * RandTicks / 3) begin
        src_idle_pct  = 84;
        sink_idle_pct = 35;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      step = pick_step();
      load_regs(6'($urandom_range(1, 63)), MethW'($urandom_range(0, 3)), pick_coeff(),
                step, pick_temp(), pick_temp(), pick_end(step));
      // stray ticks on whatever state the last block left
      len = $urandom_range(0, 2);
      queue_ticks(16'b0, len);
      rand_ticks += len;
      runs = $urandom_range(2, 4);
      for (int r = 0; r < runs; r++) begin
        pending_ticks.insert(pending_ticks.size(), 1'b1);
        len = $urandom_range(0, 14);
        for (int i = 0; i < len; i++)
          pending_ticks.insert(pending_ticks.size(), $urandom_range(0, 19) == 0);
        rand_ticks += len + 1;
      end
      settle();
    end

    if (expected_samples.size() != 0)
      report_error($sformatf("%0d samples never arrived", expected_samples.size()));
    $display("run covered %0d ticks, %0d sample words checked, %0d register writes",
             ticks_accepted, samples_checked, cfg_writes);
    $display("all methods, saturation, zero step and end-of-run cases; %0d errors",
             error_count);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
